// ----- hdl/cv3_pkg.sv -----
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared types, constants and the tap arithmetic of the streaming 3x3
// convolution with zero border.
// ----------------------------------------------------------------------------
package cv3_pkg;

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 4096;
	localparam int KERNEL_SIZE = 3;

	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 13;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 13;
	localparam int COEF_W     = 24;
	localparam int CFG_DATA_W = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int RESULT_W   = 20;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
	localparam logic [COEF_W-1:0]   COEF_RESET   = 24'h010101;

	localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(KERNEL_SIZE);
	localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(KERNEL_SIZE);
	localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(MAX_HEIGHT);

	typedef logic [7:0]               pixel_t;
	typedef logic [COL_W-1:0]         col_t;
	typedef logic [ROW_W-1:0]         row_t;
	typedef logic [COEF_W-1:0]        coef_row_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]    cfg_data_t;
	typedef logic signed [17:0]       row_sum_t;
	typedef logic signed [RESULT_W-1:0] result_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 3'd0,
		REG_IMAGE_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MID     = 3'd3,
		REG_COEF_BOT     = 3'd4
	} cfg_reg_e;

	// Three signed taps (left tap in the low byte) times three unsigned pixels.
	function automatic row_sum_t row_dot(input coef_row_t coefs, input pixel_t a,
			input pixel_t b, input pixel_t c);
		logic signed [16:0] pa;
		logic signed [16:0] pb;
		logic signed [16:0] pc;
		pa = $signed(coefs[7:0])   * $signed({1'b0, a});
		pb = $signed(coefs[15:8])  * $signed({1'b0, b});
		pc = $signed(coefs[23:16]) * $signed({1'b0, c});
		row_dot = $signed({pa[16], pa}) + $signed({pb[16], pb}) + $signed({pc[16], pc});
	endfunction

	function automatic result_t sum3(input row_sum_t a, input row_sum_t b, input row_sum_t c);
		sum3 = $signed({{2{a[17]}}, a}) + $signed({{2{b[17]}}, b})
			+ $signed({{2{c[17]}}, c});
	endfunction

endpackage

// ----- hdl/conv3x3_zero_pad_stream.sv -----
// ----------------------------------------------------------------------------
// conv3x3_zero_pad_stream
// Streaming 3x3 convolution over raster-order gray pixels with a one-pixel
// zero border; same-size output, nine signed 8-bit taps.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------
//  input    | in_valid / in_stall   | pixel, flush
//  output   | out_valid / out_stall | filtered_value, row_end, frame_end
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One pixel is taken per clock while in_stall is low. Stages, in order:
//  line RAM read, window update, per-row tap sums, output register. The
//  last pixel of a row yields two results (none in the first row), which
//  take turns in the single output register and hold stage 3 meanwhile.
//  Reset clears counters, window and valid bits and sets the config to
//  its reset values; line RAMs are not cleared.
//  An output stall backs up through the stages to in_stall.
// ----------------------------------------------------------------------------
module conv3x3_zero_pad_stream (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  cv3_pkg::pixel_t       pixel,
	input  logic                  flush,

	output logic                  out_valid,
	input  logic                  out_stall,
	output cv3_pkg::result_t      filtered_value,
	output logic                  row_end,
	output logic                  frame_end,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cv3_pkg::cfg_idx_t     cfg_index,
	input  cv3_pkg::cfg_data_t    cfg_data
);
	import cv3_pkg::*;

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	coef_row_t           coef_q [KERNEL_SIZE];
	logic [WIDTH_W-1:0]  w_eff;
	logic [HEIGHT_W-1:0] h_eff;

	// position of the next pixel
	col_t col_q;
	row_t row_q;

	// handshake
	logic accept;
	logic s1_free, s2_free, s3_free, s3_done, out_free, load_out;

	// stage 1
	logic   valid_s1;
	pixel_t pix_s1;
	col_t   col_s1;
	logic   first_col_s1, last_s1, emit_s1, pad_s1, top_zero_s1;
	pixel_t up_rd, up2_rd;

	// stage 2
	logic valid_s2, emit_s2, last_s2, pad_s2;
	logic [KERNEL_SIZE-1:0][KERNEL_SIZE-1:0][7:0] window_q;
	row_sum_t rows_n [KERNEL_SIZE];
	row_sum_t rows_p [KERNEL_SIZE];

	// stage 3
	logic     valid_s3, emit_s3, last_s3, pad_s3, sent_s3;
	row_sum_t rows_n_s3 [KERNEL_SIZE];
	row_sum_t rows_p_s3 [KERNEL_SIZE];

	// current item decode
	logic   last_col, pad_row;
	pixel_t pix_in;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WIDTH_RESET;
			height_q  <= HEIGHT_RESET;
			coef_q[0] <= COEF_RESET;
			coef_q[1] <= COEF_RESET;
			coef_q[2] <= COEF_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q   <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q  <= cfg_data[HEIGHT_W-1:0];
				REG_COEF_TOP:     coef_q[0] <= cfg_data[COEF_W-1:0];
				REG_COEF_MID:     coef_q[1] <= cfg_data[COEF_W-1:0];
				REG_COEF_BOT:     coef_q[2] <= cfg_data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = width_q;
		end
		if (height_q < HEIGHT_MIN) begin
			h_eff = HEIGHT_MIN;
		end else if (height_q > HEIGHT_MAX) begin
			h_eff = HEIGHT_MAX;
		end else begin
			h_eff = height_q;
		end
	end

	assign last_col = {1'b0, col_q} >= (w_eff - WIDTH_W'(1));
	assign pad_row  = row_q >= h_eff;
	assign pix_in   = (pad_row || flush) ? '0 : pixel;

	// stage flow, backed up from the output register
	assign out_free = !out_valid || !out_stall;
	assign load_out = valid_s3 && emit_s3 && out_free;
	assign s3_done  = valid_s3 && (!emit_s3 || (out_free && (!last_s3 || sent_s3)));
	assign s3_free  = !valid_s3 || s3_done;
	assign s2_free  = !valid_s2 || s3_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign in_stall = !s1_free;
	assign accept   = in_valid && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= pad_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// line buffers: read at request, write back when the item leaves stage 1
	cv3_line_ram u_line_above (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up_rd),
		.wr_en   (valid_s1 && s2_free),
		.wr_addr (col_s1),
		.wr_data (pix_s1)
	);

	cv3_line_ram u_line_two_above (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (col_q),
		.rd_data (up2_rd),
		.wr_en   (valid_s1 && s2_free),
		.wr_addr (col_s1),
		.wr_data (up_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1       <= pix_in;
			col_s1       <= col_q;
			first_col_s1 <= col_q == '0;
			last_s1      <= last_col;
			emit_s1      <= (row_q != '0) && (col_q != '0);
			pad_s1       <= pad_row;
			top_zero_s1  <= row_q <= ROW_W'(1);
		end
	end

	// window shift; a new row starts from a zero left border
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			window_q <= '0;
		end else begin
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
			if (valid_s1 && s2_free) begin
				for (int k = 0; k < KERNEL_SIZE; k++) begin
					if (first_col_s1) begin
						window_q[k][0] <= '0;
						window_q[k][1] <= '0;
					end else begin
						window_q[k][0] <= window_q[k][1];
						window_q[k][1] <= window_q[k][2];
					end
				end
				window_q[0][2] <= top_zero_s1 ? '0 : up2_rd;
				window_q[1][2] <= up_rd;
				window_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && s2_free) begin
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			pad_s2  <= pad_s1;
		end
	end

	// per-row tap sums: normal window and window shifted left over the right pad
	always_comb begin
		for (int k = 0; k < KERNEL_SIZE; k++) begin
			rows_n[k] = row_dot(coef_q[k], window_q[k][0], window_q[k][1], window_q[k][2]);
			rows_p[k] = row_dot(coef_q[k], window_q[k][1], window_q[k][2], 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			sent_s3  <= 1'b0;
		end else if (s3_free) begin
			valid_s3 <= valid_s2;
			sent_s3  <= 1'b0;
		end else if (load_out) begin
			sent_s3 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && s3_free) begin
			emit_s3 <= emit_s2;
			last_s3 <= last_s2;
			pad_s3  <= pad_s2;
			for (int k = 0; k < KERNEL_SIZE; k++) begin
				rows_n_s3[k] <= rows_n[k];
				rows_p_s3[k] <= rows_p[k];
			end
		end
	end

	// output register; the right-edge result follows the normal one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (sent_s3) begin
				filtered_value <= sum3(rows_p_s3[0], rows_p_s3[1], rows_p_s3[2]);
				row_end        <= 1'b1;
				frame_end      <= pad_s3;
			end else begin
				filtered_value <= sum3(rows_n_s3[0], rows_n_s3[1], rows_n_s3[2]);
				row_end        <= 1'b0;
				frame_end      <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/cv3_line_ram.sv -----
// ----------------------------------------------------------------------------
// cv3_line_ram
// One line of pixels: single write port, single registered read port.
// ----------------------------------------------------------------------------
module cv3_line_ram (
	input  logic            clk,
	input  logic            rd_en,
	input  cv3_pkg::col_t   rd_addr,
	output cv3_pkg::pixel_t rd_data,
	input  logic            wr_en,
	input  cv3_pkg::col_t   wr_addr,
	input  cv3_pkg::pixel_t wr_data
);
	import cv3_pkg::*;

	pixel_t mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
